// ----- design/tube_scan_readout_sequencer_unit_macros.svh -----
// Assertion macros used by the checker file of the tube scan readout sequencer.
`ifndef TUBE_SCAN_READOUT_SEQUENCER_UNIT_MACROS_SVH
`define TUBE_SCAN_READOUT_SEQUENCER_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define TSRS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tsrs assertion failed");

// Property checked on every clock edge, reset included.
`define TSRS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tsrs reset assertion failed");

`endif

// ----- design/tsrs_pkg.sv -----
package tsrs_pkg;

    // Phases of one scan frame, one-hot coded.
    typedef enum logic [3:0] {
        PH_RST_HIGH = 4'b0001,
        PH_RST_LOW  = 4'b0010,
        PH_CLK_HIGH = 4'b0100,
        PH_CLK_LOW  = 4'b1000
    } tsrs_phase_t;

    // Timing state seen by the sequencer core.
    typedef struct packed {
        tsrs_phase_t phase;
        logic [2:0]  half_cnt;
        logic        tick_zero;
    } tsrs_timing_t;

    // Register indexes (byte address divided by four).
    localparam logic REG_IDX_HBT = 1'b0;
    localparam logic REG_IDX_EN  = 1'b1;

    localparam logic [15:0] HBT_RESET    = 16'd10;
    localparam logic [2:0]  SAMPLE_HALF  = 3'd2;
    localparam int          TUBE_IDX_W   = 4;

    // Length of each phase in half timebases.
    function automatic logic [2:0] phase_len(input tsrs_phase_t ph);
        logic [2:0] len;
        case (ph)
            PH_RST_HIGH: len = 3'd6;
            PH_RST_LOW:  len = 3'd2;
            PH_CLK_HIGH: len = 3'd5;
            PH_CLK_LOW:  len = 3'd5;
            default:     len = 3'd6;
        endcase
        return len;
    endfunction

endpackage

// ----- design/tsrs_timing.sv -----
module tsrs_timing (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 restart,
    input  logic [15:0]          limit_ticks,
    input  logic                 last_tube,
    output tsrs_pkg::tsrs_timing_t tim,
    output logic                 tube_step
);

    tsrs_pkg::tsrs_phase_t phase_reg, phase_next;
    logic [2:0]  half_reg, half_next;
    logic [15:0] tick_reg, tick_next;

    logic [15:0] limit;
    logic [16:0] tick_inc;
    logic [2:0]  half_inc;
    logic        tick_wrap;
    logic        half_wrap;

    always_comb begin
        limit     = (limit_ticks == 16'd0) ? 16'd1 : limit_ticks;
        tick_inc  = {1'b0, tick_reg} + 17'd1;
        tick_wrap = tick_inc >= {1'b0, limit};
        half_inc  = half_reg + 3'd1;
        half_wrap = tick_wrap && (half_inc >= tsrs_pkg::phase_len(phase_reg));
        tube_step = half_wrap && (phase_reg == tsrs_pkg::PH_CLK_LOW);

        phase_next = phase_reg;
        half_next  = half_reg;
        tick_next  = tick_reg;
        if (restart) begin
            phase_next = tsrs_pkg::PH_RST_HIGH;
            half_next  = 3'd0;
            tick_next  = 16'd0;
        end else if (step) begin
            tick_next = tick_wrap ? 16'd0 : tick_inc[15:0];
            if (tick_wrap) begin
                half_next = half_wrap ? 3'd0 : half_inc;
            end
            if (half_wrap) begin
                case (phase_reg)
                    tsrs_pkg::PH_RST_HIGH: phase_next = tsrs_pkg::PH_RST_LOW;
                    tsrs_pkg::PH_RST_LOW:  phase_next = tsrs_pkg::PH_CLK_HIGH;
                    tsrs_pkg::PH_CLK_HIGH: phase_next = tsrs_pkg::PH_CLK_LOW;
                    tsrs_pkg::PH_CLK_LOW: begin
                        phase_next = last_tube ? tsrs_pkg::PH_RST_HIGH
                                               : tsrs_pkg::PH_CLK_HIGH;
                    end
                    default:               phase_next = tsrs_pkg::PH_RST_HIGH;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tsrs_pkg::PH_RST_HIGH;
            half_reg  <= 3'd0;
            tick_reg  <= 16'd0;
        end else begin
            phase_reg <= phase_next;
            half_reg  <= half_next;
            tick_reg  <= tick_next;
        end
    end

    assign tim.phase     = phase_reg;
    assign tim.half_cnt  = half_reg;
    assign tim.tick_zero = (tick_reg == 16'd0);

endmodule

// ----- design/tube_scan_readout_sequencer_unit.sv -----
// An s_ transaction passes the input register, then the result register, to the m_ side.
// Throughput: one transaction per cycle while m_tready is high; full backpressure support.
// The per-tube table read is registered, so each tick sees its tube entry at once.
// Reset (aresetn low, synchronous) clears the scan timing, the tube counter and all valid flags,
// sets half_timebase_ticks to 10 and scan_enable to 0; no clearing pass is needed.
module tube_scan_readout_sequencer_unit #(
    parameter int TUBE_COUNT = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Input ticks carrying the sampled sensor lines.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] pos_bits, [7:4] zero
    input  logic        s_tuser,   // [0] data_valid

    // One result per tick.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] reset_line, [1] clock_line, [5:2] tube_index,
                                   // [9:6] position, [10] eating, [15:11] zero
    output logic        m_tuser,   // [0] sample_taken

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TW = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
    localparam logic [TW-1:0] LAST_TUBE = TW'(TUBE_COUNT - 1);

    // ------------------------------------------------------------------
    // Configuration registers. Only bit 2 of paddr selects a register.
    // ------------------------------------------------------------------
    logic [15:0] hbt_reg, hbt_next;
    logic        en_reg, en_next;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        hbt_next = hbt_reg;
        en_next  = en_reg;
        if (cfg_wr) begin
            if (paddr[2] == tsrs_pkg::REG_IDX_HBT) begin
                hbt_next = pwdata[15:0];
            end else begin
                en_next = pwdata[0];
            end
        end
        if (paddr[2] == tsrs_pkg::REG_IDX_EN) begin
            prdata = {31'd0, en_reg};
        end else begin
            prdata = {16'd0, hbt_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hbt_reg <= tsrs_pkg::HBT_RESET;
            en_reg  <= 1'b0;
        end else begin
            hbt_reg <= hbt_next;
            en_reg  <= en_next;
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register advances whenever it is empty, or the result register
    // is empty or is being emptied in the same cycle.
    // ------------------------------------------------------------------
    logic       in_valid_reg, in_valid_next;
    logic [3:0] in_pos_reg;
    logic       in_dv_reg;
    logic       m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;
    logic       m_user_reg, m_user_next;
    logic       adv;
    logic       fire;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || adv;
    assign fire     = in_valid_reg && adv;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;
    assign m_valid_next  = fire ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // ------------------------------------------------------------------
    // Scan timing.
    // ------------------------------------------------------------------
    tsrs_pkg::tsrs_timing_t tim;
    logic          tube_step;
    logic [TW-1:0] tube_cnt_reg, tube_cnt_next;
    logic          last_tube;

    assign last_tube = (tube_cnt_reg == LAST_TUBE);

    tsrs_timing u_timing (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (fire && en_reg),
        .restart     (fire && !en_reg),
        .limit_ticks (hbt_reg),
        .last_tube   (last_tube),
        .tim         (tim),
        .tube_step   (tube_step)
    );

    always_comb begin
        tube_cnt_next = tube_cnt_reg;
        if (fire) begin
            if (!en_reg) begin
                tube_cnt_next = '0;
            end else if (tube_step) begin
                tube_cnt_next = last_tube ? '0 : TW'(tube_cnt_reg + 1'b1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tube table: one 5-bit word per tube, {eating, position}. Entries that
    // were never written read as zero through the valid flags. cur_entry_reg
    // always holds the entry of the current tube, and zero_entry_reg mirrors
    // tube 0, which is what a disabled tick reports.
    // ------------------------------------------------------------------
    logic [4:0]            tube_mem [TUBE_COUNT];
    logic [TUBE_COUNT-1:0] tube_vld_reg;
    logic [4:0]            cur_entry_reg;
    logic [4:0]            zero_entry_reg;

    logic       sample;
    logic       tbl_we;
    logic [3:0] wr_pos;
    logic       wr_eat;
    logic [3:0] cur_pos;
    logic       cur_eat;

    assign cur_pos = cur_entry_reg[3:0];
    assign cur_eat = cur_entry_reg[4];

    assign sample = en_reg && (tim.phase == tsrs_pkg::PH_CLK_HIGH)
                    && (tim.half_cnt == tsrs_pkg::SAMPLE_HALF) && tim.tick_zero;

    // A reading (data_valid low) stores the position and clears eating; an
    // empty reading on a tube parked at position 1 marks it as eating.
    assign tbl_we = fire && sample
                    && (!in_dv_reg || ((in_pos_reg == 4'd0) && (cur_pos == 4'd1)));
    assign wr_pos = in_dv_reg ? cur_pos : in_pos_reg;
    assign wr_eat = in_dv_reg;

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tube_mem[tube_cnt_reg] <= {wr_eat, wr_pos};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tube_vld_reg   <= '0;
            cur_entry_reg  <= 5'd0;
            zero_entry_reg <= 5'd0;
        end else begin
            if (tbl_we) begin
                tube_vld_reg[tube_cnt_reg] <= 1'b1;
            end
            if (tbl_we && (tube_cnt_reg == tube_cnt_next)) begin
                cur_entry_reg <= {wr_eat, wr_pos};
            end else if (tube_vld_reg[tube_cnt_next]) begin
                cur_entry_reg <= tube_mem[tube_cnt_next];
            end else begin
                cur_entry_reg <= 5'd0;
            end
            if (tbl_we && (tube_cnt_reg == '0)) begin
                zero_entry_reg <= {wr_eat, wr_pos};
            end
        end
    end

    // ------------------------------------------------------------------
    // Result formation.
    // ------------------------------------------------------------------
    logic [TW+3:0] idx_ext;
    logic [3:0]    out_idx;
    logic [3:0]    out_pos;
    logic          out_eat;
    logic          out_rst;
    logic          out_clk;

    assign idx_ext = {4'd0, tube_cnt_reg};

    always_comb begin
        if (en_reg) begin
            out_rst = (tim.phase == tsrs_pkg::PH_RST_HIGH);
            out_clk = (tim.phase == tsrs_pkg::PH_CLK_HIGH);
            out_idx = idx_ext[tsrs_pkg::TUBE_IDX_W-1:0];
            out_pos = tbl_we ? wr_pos : cur_pos;
            out_eat = tbl_we ? wr_eat : cur_eat;
        end else begin
            out_rst = 1'b0;
            out_clk = 1'b0;
            out_idx = 4'd0;
            out_pos = zero_entry_reg[3:0];
            out_eat = zero_entry_reg[4];
        end
        m_data_next = {5'd0, out_eat, out_pos, out_idx, out_clk, out_rst};
        m_user_next = sample;
    end

    // ------------------------------------------------------------------
    // Pipeline registers.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            tube_cnt_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            tube_cnt_reg <= tube_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pos_reg <= s_tdata[3:0];
            in_dv_reg  <= s_tuser;
        end
        if (fire) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- design/tsrs_checker.sv -----
`include "tube_scan_readout_sequencer_unit_macros.svh"

module tsrs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A stalled result transaction keeps its payload.
    `TSRS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // Sampling only happens while the sensor clock is high.
    `TSRS_ASSERT(a_sample_in_clk, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[1])

    // Reset and clock lines are never driven together.
    `TSRS_ASSERT(a_lines_excl, aclk, aresetn, m_tvalid |-> !(m_tdata[0] && m_tdata[1]))

    // The input side only stalls while a result is waiting.
    `TSRS_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> m_tvalid && !m_tready)

    // No result is offered right after reset.
    `TSRS_ASSERT_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind tube_scan_readout_sequencer_unit tsrs_checker u_tsrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_tube_scan_readout_sequencer_unit.sv -----
module tb_tube_scan_readout_sequencer_unit;

    // The block is built with its default of sixteen tubes.
    localparam int N_TUBES        = 16;
    // The result of a tick passes the input and result registers of the block, so a
    // few spare cycles are enough before a register write or the end of the run.
    localparam int DRAIN_CYCLES   = 4;
    // Length of the long output stall used to fill the block and stall its input.
    localparam int RX_HOLD_CYCLES = 400;

    // One result transaction, decoded from m_tdata and m_tuser.
    typedef struct packed {
        logic                            reset_line;
        logic                            clock_line;
        logic                            sample_taken;
        logic [tsrs_pkg::TUBE_IDX_W-1:0] tube_index;
        logic [3:0]                      position;
        logic                            eating;
    } tick_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;

    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [3:0] pos_bits, [7:4] zero
    logic        s_tuser;    // [0] data_valid

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;    // [0] reset_line, [1] clock_line, [5:2] tube_index,
                             // [9:6] position, [10] eating, [15:11] zero
    logic        m_tuser;    // [0] sample_taken

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Idle rates of both sides, in percent of cycles, and the long output stall.
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold = 1'b0;
    bit          stall_go = 1'b0;

    // Run statistics and the failure count.
    int          n_errors = 0;
    int          n_ticks = 0;
    int          n_samples = 0;
    int          n_eat_raised = 0;

    // Expected results of accepted ticks, oldest first.
    tick_result_t pending_tick_results[$];

    // Scan state and registers as the testbench expects them to be inside the block.
    tsrs_pkg::tsrs_phase_t mdl_phase;
    int           mdl_tube;
    int           mdl_half;
    int           mdl_ticks;
    logic [3:0]   mdl_pos[N_TUBES];
    logic         mdl_eat[N_TUBES];
    logic [15:0]  mdl_hbt;
    logic         mdl_en;

    tube_scan_readout_sequencer_unit #(
        .TUBE_COUNT(N_TUBES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // True when the next accepted tick is the one that samples the current tube:
    // clock phase high, third half timebase, first tick of it.
    function automatic bit at_sample_tick();
        return mdl_en && mdl_phase == tsrs_pkg::PH_CLK_HIGH
            && mdl_half == int'(tsrs_pkg::SAMPLE_HALF) && mdl_ticks == 0;
    endfunction

    // Works out the result of one tick and moves the expected scan state forward.
    function automatic tick_result_t predict_scan_tick(input logic [3:0] pos,
                                                       input logic dv);
        tick_result_t r;
        int           limit;
        int           half_len;
        r = '0;
        if (!mdl_en) begin
            // A disabled block holds both lines low and parks at the start of a frame.
            mdl_phase = tsrs_pkg::PH_RST_HIGH;
            mdl_tube  = 0;
            mdl_half  = 0;
            mdl_ticks = 0;
        end else begin
            r.reset_line = (mdl_phase == tsrs_pkg::PH_RST_HIGH);
            r.clock_line = (mdl_phase == tsrs_pkg::PH_CLK_HIGH);
            if (at_sample_tick()) begin
                r.sample_taken = 1'b1;
                n_samples++;
                if (!dv) begin
                    // A position reading is present: store it and clear eating.
                    mdl_pos[mdl_tube] = pos;
                    mdl_eat[mdl_tube] = 1'b0;
                end else if (pos == 4'd0 && mdl_pos[mdl_tube] == 4'd1) begin
                    if (!mdl_eat[mdl_tube]) begin
                        n_eat_raised++;
                    end
                    mdl_eat[mdl_tube] = 1'b1;
                end
            end
        end
        r.tube_index = mdl_tube[tsrs_pkg::TUBE_IDX_W-1:0];
        r.position   = mdl_pos[mdl_tube];
        r.eating     = mdl_eat[mdl_tube];

        if (mdl_en) begin
            // A tick count of zero behaves as one. When the count was lowered below
            // the running tick counter, the half timebase ends on this tick.
            limit = (mdl_hbt == 16'd0) ? 1 : int'(mdl_hbt);
            mdl_ticks++;
            if (mdl_ticks >= limit) begin
                mdl_ticks = 0;
                mdl_half++;
                case (mdl_phase)
                    tsrs_pkg::PH_RST_HIGH: half_len = 6;
                    tsrs_pkg::PH_RST_LOW:  half_len = 2;
                    default:               half_len = 5;
                endcase
                if (mdl_half >= half_len) begin
                    mdl_half = 0;
                    case (mdl_phase)
                        tsrs_pkg::PH_RST_HIGH: mdl_phase = tsrs_pkg::PH_RST_LOW;
                        tsrs_pkg::PH_RST_LOW:  mdl_phase = tsrs_pkg::PH_CLK_HIGH;
                        tsrs_pkg::PH_CLK_HIGH: mdl_phase = tsrs_pkg::PH_CLK_LOW;
                        default: begin
                            // End of a clock period: next tube, or a new frame
                            // after the last one.
                            mdl_tube++;
                            if (mdl_tube >= N_TUBES) begin
                                mdl_tube  = 0;
                                mdl_phase = tsrs_pkg::PH_RST_HIGH;
                            end else begin
                                mdl_phase = tsrs_pkg::PH_CLK_HIGH;
                            end
                        end
                    endcase
                end
            end
        end
        return r;
    endfunction

    // Stops offering ticks and waits until every expected result has arrived,
    // then lets the pipeline run empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_tick_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write with setup and access cycles, only ever issued on an idle block.
    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == tsrs_pkg::REG_IDX_HBT) begin
            mdl_hbt = value[15:0];
        end else begin
            mdl_en = value[0];
        end
    endtask

    // Offers one tick, after idle cycles drawn one by one at the sender's idle rate,
    // and records its expected result once the transaction is accepted. tvalid
    // stays high for the next tick and is only lowered by an idle cycle or settle().
    task automatic send_tick(input logic [3:0] pos, input logic dv);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, pos};
        s_tuser  <= dv;
        do @(posedge aclk); while (!s_tready);
        pending_tick_results.push_back(predict_scan_tick(pos, dv));
        n_ticks++;
    endtask

    // Random tick. On a sampling tick the lines mostly carry a well-formed reading:
    // position 1, then a later "no reading, all zero" that raises eating.
    task automatic send_scan_tick();
        logic [3:0] pos;
        logic       dv;
        int         pick;
        pos = 4'($urandom);
        dv  = 1'($urandom);
        if (at_sample_tick()) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                pos = 4'd1;
                dv  = 1'b0;
            end else if (pick < 7) begin
                pos = 4'd0;
                dv  = 1'b1;
            end else if (pick < 8) begin
                dv = 1'b0;
            end
        end
        send_tick(pos, dv);
    endtask

    // After reset the scan is off: both lines low, no sampling, tube 0 shown.
    task automatic test_scan_disabled();
        send_tick(4'hF, 1'b0);
        send_tick(4'h0, 1'b1);
    endtask

    // A tick count of zero runs as one tick per half timebase. The first two tubes
    // get sampled: tube 0 takes position 1, tube 1 sees no reading.
    task automatic test_zero_tick_count();
        int k;
        int n_hits;
        n_hits = 0;
        apb_write(tsrs_pkg::REG_IDX_HBT, {16'($urandom), 16'd0});
        apb_write(tsrs_pkg::REG_IDX_EN, {31'($urandom), 1'b1});
        for (k = 0; k < 21; k++) begin
            if (at_sample_tick()) begin
                if (n_hits == 0) begin
                    send_tick(4'd1, 1'b0);
                end else begin
                    send_tick(4'd0, 1'b1);
                end
                n_hits++;
            end else begin
                send_tick(k[0] ? 4'hF : 4'h0, k[0]);
            end
        end
    endtask

    // The largest tick count, then a small one written while the tick counter is
    // already past it, then a disable in mid frame with the tables kept.
    task automatic test_tick_count_lowered();
        int k;
        apb_write(tsrs_pkg::REG_IDX_HBT, 32'h0000_FFFF);
        for (k = 0; k < 6; k++) begin
            send_scan_tick();
        end
        apb_write(tsrs_pkg::REG_IDX_HBT, 32'd3);
        for (k = 0; k < 4; k++) begin
            send_scan_tick();
        end
        apb_write(tsrs_pkg::REG_IDX_EN, 32'd0);
        send_tick(4'hF, 1'b0);
        send_tick(4'h0, 1'b1);
        apb_write(tsrs_pkg::REG_IDX_EN, 32'd1);
    endtask

    // Random ticks in chunks, each chunk with a fresh tick count (mostly small so
    // that whole frames pass) and now and then a short disabled stretch.
    task automatic test_random_scan(input int tx_pct, input int rx_pct, input int n_items);
        int          sent;
        int          chunk;
        int          k;
        int          pick;
        logic [15:0] hbt;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                hbt = 16'd1;
            end else if (pick < 16) begin
                hbt = 16'd2;
            end else if (pick < 18) begin
                hbt = 16'd3;
            end else begin
                hbt = 16'($urandom_range(0, 6));
            end
            apb_write(tsrs_pkg::REG_IDX_HBT, {16'($urandom), hbt});
            if ($urandom_range(0, 7) == 0) begin
                apb_write(tsrs_pkg::REG_IDX_EN, {31'($urandom), 1'b0});
                for (k = 0; k < 3; k++) begin
                    send_scan_tick();
                end
                apb_write(tsrs_pkg::REG_IDX_EN, {31'($urandom), 1'b1});
                sent += 3;
            end
            chunk = $urandom_range(30, 90);
            for (k = 0; k < chunk; k++) begin
                send_scan_tick();
            end
            sent += chunk;
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // ticks back to back, so the block fills up and stalls its input.
    task automatic test_output_backpressure();
        int k;
        apb_write(tsrs_pkg::REG_IDX_HBT, 32'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_go = 1'b1;
        for (k = 0; k < 80; k++) begin
            send_scan_tick();
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Counts out the long output stall once the backpressure test asks for it.
    initial begin
        wait (stall_go);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Result side: every accepted result transaction is compared field by field
    // with the oldest expectation, and tready is redrawn for the next cycle.
    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tick_results.size() == 0) begin
                $error("result transaction arrived with no tick pending");
                n_errors++;
            end else begin
                want = pending_tick_results.pop_front();
                check_field("reset_line",   want.reset_line,   m_tdata[0]);
                check_field("clock_line",   want.clock_line,   m_tdata[1]);
                check_field("tube_index",   want.tube_index,   m_tdata[5:2]);
                check_field("position",     want.position,     m_tdata[9:6]);
                check_field("eating",       want.eating,       m_tdata[10]);
                check_field("sample_taken", want.sample_taken, m_tuser);
            end
        end
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Main sequence: reset once, directed checks, three random idling mixes, then
    // the output stall, and the verdict once the last result has been checked.
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= 3'd0;
        pwdata   <= 32'd0;
        mdl_phase = tsrs_pkg::PH_RST_HIGH;
        mdl_tube  = 0;
        mdl_half  = 0;
        mdl_ticks = 0;
        mdl_hbt   = tsrs_pkg::HBT_RESET;
        mdl_en    = 1'b0;
        for (int i = 0; i < N_TUBES; i++) begin
            mdl_pos[i] = 4'd0;
            mdl_eat[i] = 1'b0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_scan_disabled();
        test_zero_tick_count();
        test_tick_count_lowered();
        test_random_scan(16, 68, 330);
        test_random_scan(68, 16, 330);
        test_random_scan(0, 0, 330);
        test_output_backpressure();
        settle();

        $display("Checked %0d ticks with %0d tube samples and %0d eating flags raised.",
                 n_ticks, n_samples, n_eat_raised);
        $display("Tick counts 0 to 6, 65535 and a mid-count drop, scan on and off, %s",
                 "three idling mixes and a long output stall.");
        if (n_errors == 0) begin
            $display("tb_tube_scan_readout_sequencer_unit: PASS");
        end else begin
            $display("tb_tube_scan_readout_sequencer_unit: FAIL");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb_tube_scan_readout_sequencer_unit: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/tsrs_pkg.sv
design/tsrs_timing.sv
design/tube_scan_readout_sequencer_unit.sv
design/tsrs_checker.sv
tb/sv/tb_tube_scan_readout_sequencer_unit.sv
